@@ rtl/ect_pkg.sv @@
// Package for the exposure countdown timer.
// Register indexes, reset values, field widths and the structs shared by the
// top level and the tick-update core. No dependencies.
`default_nettype none

package ect_pkg;

    // Field widths
    localparam int unsigned DebW   = 10;
    localparam int unsigned UnitW  = 16;
    localparam int unsigned MaxW   = 4;
    localparam int unsigned CountW = 5;

    // Config port widths
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_UNIT_TICKS     = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MAX_COUNT      = 2'd2;

    // Reset values of the registers
    localparam logic [DebW-1:0]  DEBOUNCE_TICKS_RST = 10'd60;
    localparam logic [UnitW-1:0] UNIT_TICKS_RST     = 16'd2164;
    localparam logic [MaxW-1:0]  MAX_COUNT_RST      = 4'd15;

    // Hard ceiling on the unit count
    localparam logic [CountW-1:0] COUNT_CEIL = 5'd16;

    typedef struct packed {
        logic [DebW-1:0]  debounce_ticks;
        logic [UnitW-1:0] unit_ticks;
        logic [MaxW-1:0]  max_count;
    } t_cfg;

    typedef struct packed {
        logic              relay_on;
        logic              led_on;
        logic [CountW-1:0] units_left;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/ect_core.sv @@
// Tick-update core of the exposure countdown timer: hold, unit and blink state
// plus the next-state logic for one tick. Uses ect_pkg.
`default_nettype none

module ect_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic           i_button_pressed,
    input  wire ect_pkg::t_cfg  i_cfg,
    output ect_pkg::t_result    o_result
);
    import ect_pkg::*;

    logic [DebW-1:0]   r_hold_ticks,      n_hold_ticks;
    logic [UnitW-1:0]  r_unit_left_ticks, n_unit_left_ticks;
    logic [CountW-1:0] r_unit_count,      n_unit_count;
    logic              r_blink,           n_blink;
    logic              r_relay,           n_relay;

    logic              expired;
    logic              hold_done;
    logic              led;
    logic [DebW:0]     hold_inc;
    logic [UnitW-1:0]  unit_reload;
    logic [CountW-1:0] kept_count;
    logic [CountW-1:0] max_ext;

    assign expired  = (r_unit_left_ticks == '0);
    assign hold_inc = {1'b0, r_hold_ticks} + {{DebW{1'b0}}, 1'b1};
    assign hold_done = (hold_inc >= {1'b0, i_cfg.debounce_ticks});
    assign max_ext  = {{(CountW-MaxW){1'b0}}, i_cfg.max_count};
    // count kept on release: above max clears to zero
    assign kept_count = (r_unit_count > max_ext) ? '0 : r_unit_count;

    // next state for one tick
    always_comb begin
        n_hold_ticks = r_hold_ticks;
        unit_reload  = r_unit_left_ticks;
        n_unit_count = r_unit_count;
        n_blink      = r_blink;
        n_relay      = r_relay;
        led          = 1'b0;

        if (r_blink) begin
            // dark tick of a blink, button ignored
            n_blink = 1'b0;
        end else if (i_button_pressed) begin
            n_relay = 1'b0;
            if (hold_done) begin
                if ((r_unit_count <= max_ext) && (r_unit_count < COUNT_CEIL)) begin
                    n_unit_count = r_unit_count + 1'b1;
                end
                n_hold_ticks = '0;
                unit_reload  = i_cfg.unit_ticks;
                led          = 1'b1;
                n_blink      = 1'b1;
            end else begin
                n_hold_ticks = hold_inc[DebW-1:0];
            end
        end else begin
            n_hold_ticks = '0;
            n_unit_count = kept_count;
            if (kept_count != '0) begin
                n_relay = 1'b1;
                if (expired) begin
                    unit_reload  = i_cfg.unit_ticks;
                    n_unit_count = kept_count - 1'b1;
                end else if (kept_count == {{(CountW-1){1'b0}}, 1'b1}) begin
                    // last unit running: keep blinking
                    led     = 1'b1;
                    n_blink = 1'b1;
                end
            end else begin
                n_relay = 1'b0;
            end
        end

        // unit timer counts down toward zero every tick
        n_unit_left_ticks = (unit_reload != '0) ? unit_reload - 1'b1 : unit_reload;
    end

    // state registers, advanced once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks      <= '0;
            r_unit_left_ticks <= '0;
            r_unit_count      <= '0;
            r_blink           <= 1'b0;
            r_relay           <= 1'b0;
        end else if (i_step) begin
            r_hold_ticks      <= n_hold_ticks;
            r_unit_left_ticks <= n_unit_left_ticks;
            r_unit_count      <= n_unit_count;
            r_blink           <= n_blink;
            r_relay           <= n_relay;
        end
    end

    assign o_result.relay_on   = n_relay;
    assign o_result.led_on     = led;
    assign o_result.units_left = n_unit_count;

endmodule

`default_nettype wire

@@ rtl/exposure_countdown_timer.sv @@
// Exposure countdown timer top level: config registers, input/output handshake
// and the result register. Uses ect_pkg and ect_core.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one word per timer tick holding
//   the button level. Each accepted word produces exactly one result word on
//   the output channel (o_valid / i_stall): relay drive, LED drive and the
//   current unit count.
//   The result of an accepted word is registered and shown from the cycle
//   after it is taken. Throughput is one word per cycle while the receiver
//   does not stall; the whole tick update is a single pass of logic from the
//   state registers into the result register.
//   While the receiver stalls, the held result stays put and o_stall rises so
//   no new word is taken; if the receiver takes the result in the same cycle,
//   a new word is accepted alongside.
//   Config writes (i_cfg_valid / o_cfg_ready, always ready) go to
//   debounce_ticks (0), unit_ticks (1) and max_count (2); other indexes are
//   dropped. Write only while idle.
//   Synchronous reset clears all timer state, loads the default register
//   values and clears the result valid flag; the result payload is not reset.
`default_nettype none

module exposure_countdown_timer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // tick input
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_button_pressed,
    // result output
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_relay_on,
    output logic                                o_led_on,
    output logic [ect_pkg::CountW-1:0]          o_units_left,
    // config writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ect_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [ect_pkg::CfgDataW-1:0]   i_cfg_data
);
    import ect_pkg::*;

    t_cfg    r_cfg;
    t_result core_result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_accept;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_TICKS_RST;
            r_cfg.unit_ticks     <= UNIT_TICKS_RST;
            r_cfg.max_count      <= MAX_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DEBOUNCE_TICKS: r_cfg.debounce_ticks <= i_cfg_data[DebW-1:0];
                REG_UNIT_TICKS:     r_cfg.unit_ticks     <= i_cfg_data[UnitW-1:0];
                REG_MAX_COUNT:      r_cfg.max_count      <= i_cfg_data[MaxW-1:0];
                default: ;
            endcase
        end
    end

    // take a word unless a finished result is blocked downstream
    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    ect_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (in_accept),
        .i_button_pressed (i_button_pressed),
        .i_cfg            (r_cfg),
        .o_result         (core_result)
    );

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= core_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_relay_on   = r_result.relay_on;
    assign o_led_on     = r_result.led_on;
    assign o_units_left = r_result.units_left;

endmodule

`default_nettype wire
